[rtl/gda_pkg.sv]
package gda_pkg;

  localparam int unsigned EPOCH_YEAR_DEFAULT = 1753;
  localparam int unsigned YEAR_BITS_DEFAULT  = 12;
  localparam int unsigned STEP_BITS_DEFAULT  = 16;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_DATE = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  typedef struct packed {
    logic start;
    logic step;
  } gda_walk_ctl_t;

  // days in month m, 0 for a month code that is not a month
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                         len = leap ? 5'd29 : 5'd28;
      default:                                      len = 5'd0;
    endcase
    return len;
  endfunction

  // days of a common year before the first of month m
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] sum;
    case (m)
      4'd2:    sum = 9'd31;
      4'd3:    sum = 9'd59;
      4'd4:    sum = 9'd90;
      4'd5:    sum = 9'd120;
      4'd6:    sum = 9'd151;
      4'd7:    sum = 9'd181;
      4'd8:    sum = 9'd212;
      4'd9:    sum = 9'd243;
      4'd10:   sum = 9'd273;
      4'd11:   sum = 9'd304;
      4'd12:   sum = 9'd334;
      default: sum = 9'd0;
    endcase
    return sum;
  endfunction

endpackage

[rtl/gregorian_date_advance_unit.sv]
// channel | signals                                   | dir | handshake
// input   | month day year days_ahead                 | in  | in_valid / in_ready
// output  | status later_month later_day later_year   | out | out_valid / out_ready
//         | weekday ordinal leap                      |     |
//
// one word at a time; in_ready is high only while the sequencer is idle
// each word is worked through by the year walker and the single shared subtract/compare unit
// a bad date with a year before the epoch skips the year walk and goes straight to the done state
// rst is synchronous and clears the sequencer and the output valid flag
// a finished word sits in the output register, so the next word can start under a stall
module gregorian_date_advance_unit import gda_pkg::*; #(
  parameter int unsigned EPOCH_YEAR = EPOCH_YEAR_DEFAULT,
  parameter int unsigned YEAR_BITS  = YEAR_BITS_DEFAULT,
  parameter int unsigned STEP_BITS  = STEP_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  month,
  input  logic [4:0]  day,
  input  logic [11:0] year,
  input  logic [15:0] days_ahead,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [3:0]  later_month,
  output logic [4:0]  later_day,
  output logic [11:0] later_year,
  output logic [2:0]  weekday,
  output logic [8:0]  ordinal,
  output logic        leap
);

  localparam int unsigned YW  = YEAR_BITS + 1;
  localparam int unsigned AW  = (STEP_BITS > 9) ? STEP_BITS : 9;
  localparam int unsigned PW  = (STEP_BITS > 16) ? STEP_BITS : 16;
  localparam logic [11:0]   EpochYr = 12'(EPOCH_YEAR);
  localparam logic [YW-1:0] MaxYear = {1'b0, {YEAR_BITS{1'b1}}};

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_YEAR = 3'd1;
  localparam logic [2:0] S_MOD7 = 3'd2;
  localparam logic [2:0] S_ADV  = 3'd3;
  localparam logic [2:0] S_MON  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]           state, state_next;
  logic [3:0]           m_r;
  logic [4:0]           d_r;
  logic [11:0]          y_r;
  logic [STEP_BITS-1:0] n, n_next;
  logic [8:0]           k, k_next;
  logic [3:0]           lm, lm_next;
  logic [2:0]           wd, wd_next;
  logic [1:0]           st, st_next;
  logic [8:0]           ord, ord_next;
  logic                 lp, lp_next;
  logic                 load_out;

  gda_walk_ctl_t        walk;
  logic [YW-1:0]        wy;
  logic                 walk_leap;

  logic [AW-1:0]        alu_a, alu_b, alu_diff;
  logic                 alu_borrow, alu_zero;

  logic [PW-1:0]        ahead_wide;
  logic [STEP_BITS-1:0] n_load;
  logic [8:0]           ord_calc;
  logic                 date_ok;
  logic [3:0]           wsum;
  logic [2:0]           wd_adv;
  logic [8:0]           diy, rem;
  logic [AW-1:0]        adv_sum;

  gda_year_walker #(
    .EPOCH_YEAR (EPOCH_YEAR),
    .YEAR_BITS  (YEAR_BITS)
  ) u_walker (
    .clk      (clk),
    .ctl      (walk),
    .year_cur (wy),
    .leap     (walk_leap)
  );

  gda_alu #(
    .WIDTH (AW)
  ) u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .diff   (alu_diff),
    .borrow (alu_borrow),
    .zero   (alu_zero)
  );

  assign in_ready   = (state == S_IDLE);
  assign ahead_wide = PW'(days_ahead);
  assign n_load     = ahead_wide[STEP_BITS-1:0];

  assign ord_calc = days_before(m_r) + 9'(d_r) + 9'(walk_leap && (m_r > 4'd2));
  assign date_ok  = (m_r >= 4'd1) && (m_r <= 4'd12) && (d_r != 5'd0) &&
                    (d_r <= month_days(m_r, walk_leap));

  // a common year moves the weekday by one, a leap year by two
  assign wsum   = {1'b0, wd} + (walk_leap ? 4'd2 : 4'd1);
  assign wd_adv = (wsum >= 4'd7) ? 3'(wsum - 4'd7) : wsum[2:0];

  assign diy     = walk_leap ? 9'd366 : 9'd365;
  assign rem     = diy - k;
  assign adv_sum = AW'(k) + AW'(n);

  always_comb begin
    case (state)
      S_MOD7: begin
        alu_a = AW'(k);
        alu_b = AW'(7);
      end
      S_ADV: begin
        alu_a = AW'(n);
        alu_b = AW'(rem);
      end
      S_MON: begin
        alu_a = AW'(k);
        alu_b = AW'(month_days(lm, walk_leap));
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    n_next     = n;
    k_next     = k;
    lm_next    = lm;
    wd_next    = wd;
    st_next    = st;
    ord_next   = ord;
    lp_next    = lp;
    walk.start = 1'b0;
    walk.step  = 1'b0;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          n_next  = n_load;
          wd_next = 3'd0;
          if (year < EpochYr) begin
            st_next    = ST_BAD_DATE;
            state_next = S_DONE;
          end else begin
            st_next    = ST_OK;
            walk.start = 1'b1;
            state_next = S_YEAR;
          end
        end
      end
      S_YEAR: begin
        if (wy == YW'(y_r)) begin
          lp_next  = walk_leap;
          ord_next = ord_calc;
          if (!date_ok) begin
            st_next    = ST_BAD_DATE;
            state_next = S_DONE;
          end else begin
            k_next     = ord_calc + 9'(wd);
            state_next = S_MOD7;
          end
        end else begin
          walk.step = 1'b1;
          wd_next   = wd_adv;
        end
      end
      S_MOD7: begin
        if (alu_borrow) begin
          wd_next    = k[2:0];
          k_next     = ord;
          state_next = S_ADV;
        end else begin
          k_next = alu_diff[8:0];
        end
      end
      S_ADV: begin
        // the rest of the step fits in this year
        if (alu_borrow || alu_zero) begin
          k_next     = adv_sum[8:0];
          lm_next    = 4'd1;
          state_next = S_MON;
        end else begin
          n_next = alu_diff[STEP_BITS-1:0];
          k_next = 9'd0;
          if (wy == MaxYear) begin
            st_next    = ST_RANGE;
            state_next = S_DONE;
          end else begin
            walk.step = 1'b1;
          end
        end
      end
      S_MON: begin
        if ((lm < 4'd12) && !(alu_borrow || alu_zero)) begin
          k_next  = alu_diff[8:0];
          lm_next = lm + 4'd1;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      m_r <= month;
      d_r <= day;
      y_r <= year;
    end
    n   <= n_next;
    k   <= k_next;
    lm  <= lm_next;
    wd  <= wd_next;
    st  <= st_next;
    ord <= ord_next;
    lp  <= lp_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status <= st;
      if (st == ST_BAD_DATE) begin
        later_month <= 4'd0;
        later_day   <= 5'd0;
        later_year  <= 12'd0;
        weekday     <= 3'd0;
        ordinal     <= 9'd0;
        leap        <= 1'b0;
      end else begin
        weekday <= wd;
        ordinal <= ord;
        leap    <= lp;
        if (st == ST_RANGE) begin
          later_month <= 4'd0;
          later_day   <= 5'd0;
          later_year  <= 12'd0;
        end else begin
          later_month <= lm;
          later_day   <= k[4:0];
          later_year  <= wy[11:0];
        end
      end
    end
  end

endmodule

[rtl/gda_alu.sv]
module gda_alu import gda_pkg::*; #(
  parameter int unsigned WIDTH = 16
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic [WIDTH-1:0] diff,
  output logic             borrow,
  output logic             zero
);

  logic [WIDTH:0] full;

  assign full   = {1'b0, a} - {1'b0, b};
  assign diff   = full[WIDTH-1:0];
  assign borrow = full[WIDTH];
  assign zero   = (full[WIDTH-1:0] == '0);

endmodule

[rtl/gda_year_walker.sv]
module gda_year_walker import gda_pkg::*; #(
  parameter int unsigned EPOCH_YEAR = EPOCH_YEAR_DEFAULT,
  parameter int unsigned YEAR_BITS  = YEAR_BITS_DEFAULT
) (
  input  logic                 clk,
  input  gda_walk_ctl_t        ctl,
  output logic [YEAR_BITS:0]   year_cur,
  output logic                 leap
);

  localparam int unsigned YW = YEAR_BITS + 1;
  localparam logic [1:0] Res4   = 2'(EPOCH_YEAR % 4);
  localparam logic [6:0] Res100 = 7'(EPOCH_YEAR % 100);
  localparam logic [8:0] Res400 = 9'(EPOCH_YEAR % 400);

  logic [1:0] c4;
  logic [6:0] c100;
  logic [8:0] c400;

  // residues of the current year track the leap rule without a divider
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      year_cur <= YW'(EPOCH_YEAR);
      c4       <= Res4;
      c100     <= Res100;
      c400     <= Res400;
    end else if (ctl.step) begin
      year_cur <= year_cur + YW'(1);
      c4       <= c4 + 2'd1;
      c100     <= (c100 == 7'd99) ? 7'd0 : c100 + 7'd1;
      c400     <= (c400 == 9'd399) ? 9'd0 : c400 + 9'd1;
    end
  end

  assign leap = (c4 == 2'd0) && ((c100 != 7'd0) || (c400 == 9'd0));

endmodule
